FILE: src/fpr_pkg.sv
package fpr_pkg;

    localparam int MAX_PAGES_DEF    = 16;
    localparam int PAGE_ID_BITS_DEF = 16;
    localparam int LIMIT_RESET      = 4;

    localparam logic [2:0] ADDR_LIMIT = 3'd0;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } fpr_state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } fpr_cmd_t;

    typedef struct packed {
        logic out_free;
    } fpr_status_t;

endpackage

FILE: src/fpr_ctrl.sv
module fpr_ctrl
    import fpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  fpr_status_t status,
    output fpr_cmd_t    cmd
);

    fpr_state_t state_reg;
    fpr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_LOOKUP:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: src/fpr_datapath.sv
module fpr_datapath
    import fpr_pkg::*;
#(
    parameter int MAX_PAGES    = MAX_PAGES_DEF,
    parameter int PAGE_ID_BITS = PAGE_ID_BITS_DEF,
    parameter int SLOT_W       = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
    parameter int COUNT_W      = $clog2(MAX_PAGES + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  fpr_cmd_t                cmd,
    output fpr_status_t             status,
    input  logic [PAGE_ID_BITS-1:0] page_number,
    input  logic                    cfg_write,
    input  logic [COUNT_W-1:0]      cfg_value,
    output logic [COUNT_W-1:0]      limit,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    hit,
    output logic                    evicted,
    output logic [PAGE_ID_BITS-1:0] evicted_page,
    output logic [SLOT_W-1:0]       filled_slot,
    output logic [COUNT_W-1:0]      resident_count
);

    localparam int LIMIT_INIT = (LIMIT_RESET > MAX_PAGES) ? MAX_PAGES : LIMIT_RESET;
    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(MAX_PAGES - 1);
    localparam logic [COUNT_W:0]   DEPTH_EXT = (COUNT_W + 1)'(MAX_PAGES);

    logic [PAGE_ID_BITS-1:0] slot_page_reg [MAX_PAGES];
    logic [MAX_PAGES-1:0]    slot_valid_reg;
    logic [MAX_PAGES-1:0]    slot_valid_next;
    logic [SLOT_W-1:0]       oldest_reg;
    logic [SLOT_W-1:0]       oldest_next;
    logic [COUNT_W-1:0]      count_reg;
    logic [COUNT_W-1:0]      count_next;
    logic [COUNT_W-1:0]      limit_reg;
    logic [COUNT_W-1:0]      limit_next;
    logic [PAGE_ID_BITS-1:0] page_reg;

    logic                    out_valid_reg;
    logic                    out_hit_reg;
    logic                    out_evicted_reg;
    logic [PAGE_ID_BITS-1:0] out_evicted_page_reg;
    logic [SLOT_W-1:0]       out_slot_reg;
    logic [COUNT_W-1:0]      out_count_reg;

    logic [MAX_PAGES-1:0]    match;
    logic                    lookup_hit;
    logic [SLOT_W-1:0]       hit_slot;
    logic                    do_evict;
    logic [COUNT_W-1:0]      count_mid;
    logic [COUNT_W:0]        slot_sum;
    logic [SLOT_W-1:0]       write_slot;
    logic [SLOT_W-1:0]       result_slot;
    logic [COUNT_W-1:0]      sat_value;

    always_comb
    begin
        for (int i = 0; i < MAX_PAGES; i++)
        begin
            match[i] = slot_valid_reg[i] && (slot_page_reg[i] == page_reg);
        end
    end

    always_comb
    begin
        lookup_hit = |match;
        hit_slot   = '0;
        for (int i = MAX_PAGES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_slot = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        do_evict    = !lookup_hit && (count_reg >= limit_reg) && (count_reg != '0);
        oldest_next = oldest_reg;
        count_mid   = count_reg;
        if (do_evict)
        begin
            oldest_next = (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + 1'b1;
            count_mid   = count_reg - 1'b1;
        end
        slot_sum = {{(COUNT_W + 1 - SLOT_W){1'b0}}, oldest_next} + {1'b0, count_mid};
        if (slot_sum >= DEPTH_EXT)
        begin
            slot_sum = slot_sum - DEPTH_EXT;
        end
        write_slot  = slot_sum[SLOT_W-1:0];
        result_slot = lookup_hit ? hit_slot : write_slot;
        count_next  = lookup_hit ? count_reg : count_mid + 1'b1;
        slot_valid_next = slot_valid_reg;
        if (!lookup_hit)
        begin
            if (do_evict)
            begin
                slot_valid_next[oldest_reg] = 1'b0;
            end
            slot_valid_next[write_slot] = 1'b1;
        end
    end

    always_comb
    begin
        sat_value = cfg_value;
        if (cfg_value == '0)
        begin
            sat_value = COUNT_W'(1);
        end
        else if (cfg_value > COUNT_W'(MAX_PAGES))
        begin
            sat_value = COUNT_W'(MAX_PAGES);
        end
        limit_next = limit_reg;
        if (cfg_write && (count_reg == '0))
        begin
            limit_next = sat_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            oldest_reg     <= '0;
            count_reg      <= '0;
            limit_reg      <= COUNT_W'(LIMIT_INIT);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            limit_reg <= limit_next;
            if (cmd.commit)
            begin
                slot_valid_reg <= slot_valid_next;
                oldest_reg     <= lookup_hit ? oldest_reg : oldest_next;
                count_reg      <= count_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            page_reg <= page_number;
        end
        if (cmd.commit)
        begin
            if (!lookup_hit)
            begin
                slot_page_reg[write_slot] <= page_reg;
            end
            out_hit_reg          <= lookup_hit;
            out_evicted_reg      <= do_evict;
            out_evicted_page_reg <= do_evict ? slot_page_reg[oldest_reg] : '0;
            out_slot_reg         <= result_slot;
            out_count_reg        <= count_next;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign limit           = limit_reg;
    assign out_valid       = out_valid_reg;
    assign hit             = out_hit_reg;
    assign evicted         = out_evicted_reg;
    assign evicted_page    = out_evicted_page_reg;
    assign filled_slot     = out_slot_reg;
    assign resident_count  = out_count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while still waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= limit_reg)
        else $error("resident count above limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_evicted_reg) |-> !out_hit_reg)
        else $error("eviction reported on a hit");

    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_valid_reg) == int'(count_reg))
        else $error("valid bits disagree with resident count");

endmodule

FILE: src/fifo_page_replacement.sv
// FIFO page replacement table. Each input word carries one page reference; each
// reference yields exactly one output word with the hit flag, the eviction flag and
// evicted page, the slot that holds the page and the resident count afterwards. The
// lookup compares all slots at once. A reference is first captured in the page
// register, then looked up and the table updated once the output register is
// free; the input is stalled from capture until that update. A finished word waits
// in the output register without blocking the next capture. The table is empty after
// reset. resident_limit sits at byte address 0, is saturated to the range 1 to
// MAX_PAGES, and is written only while no page is resident.
module fifo_page_replacement
    import fpr_pkg::*;
#(
    parameter int MAX_PAGES    = MAX_PAGES_DEF,
    parameter int PAGE_ID_BITS = PAGE_ID_BITS_DEF,
    parameter int SLOT_W       = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
    parameter int COUNT_W      = $clog2(MAX_PAGES + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [PAGE_ID_BITS-1:0] page_number,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    hit,
    output logic                    evicted,
    output logic [PAGE_ID_BITS-1:0] evicted_page,
    output logic [SLOT_W-1:0]       filled_slot,
    output logic [COUNT_W-1:0]      resident_count
);

    fpr_cmd_t           cmd;
    fpr_status_t        status;
    logic               cfg_write;
    logic [COUNT_W-1:0] limit;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_LIMIT);
    assign prdata    = (paddr == ADDR_LIMIT) ? 32'(limit) : '0;

    fpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    fpr_datapath #(
        .MAX_PAGES    (MAX_PAGES),
        .PAGE_ID_BITS (PAGE_ID_BITS),
        .SLOT_W       (SLOT_W),
        .COUNT_W      (COUNT_W)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .page_number    (page_number),
        .cfg_write      (cfg_write),
        .cfg_value      (pwdata[COUNT_W-1:0]),
        .limit          (limit),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .evicted        (evicted),
        .evicted_page   (evicted_page),
        .filled_slot    (filled_slot),
        .resident_count (resident_count)
    );

endmodule
